@@ hw/rtl/mac_log_record_bsr_parser_core_defines.svh @@
// Assertion macros used by the parser core RTL.
// Each macro expects clk and rst_n in scope of the module that uses it.
`ifndef MAC_LOG_RECORD_BSR_PARSER_CORE_DEFINES_SVH
`define MAC_LOG_RECORD_BSR_PARSER_CORE_DEFINES_SVH

// Same-cycle implication.
`define MLBP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MLBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mlbp_pkg.sv @@
package mlbp_pkg;

    // Record parse phase
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_REC  = 3'd1,
        PH_SUB  = 3'd2,
        PH_SAMP = 3'd3,
        PH_ELEM = 3'd4
    } phase_t;

    // MAC subheader walk state
    typedef enum logic [2:0] {
        WK_SUBHDR = 3'd0,
        WK_LEN1   = 3'd1,
        WK_LEN2   = 3'd2,
        WK_CE0    = 3'd3,
        WK_CE1    = 3'd4,
        WK_CE2    = 3'd5,
        WK_DONE   = 3'd6
    } walk_t;

    // BSR kind codes
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_SHORT = 2'd1;
    localparam logic [1:0] KIND_LONG  = 2'd2;
    localparam logic [1:0] KIND_PAD   = 2'd3;

    localparam logic signed [2:0] GROUP_NONE = -3'sd1;

    // LCID values of interest
    localparam logic [4:0] LCID_SHORT_BSR = 5'd29;
    localparam logic [4:0] LCID_LONG_BSR  = 5'd30;
    localparam logic [4:0] LCID_PADDING   = 5'd31;
    localparam logic [4:0] LCID_MAX_SDU   = 5'd11;

    // Header geometry (octet offsets)
    localparam logic [7:0] REC_HDR_LAST   = 8'd3;
    localparam logic [7:0] SUB_HDR_LAST   = 8'd4;
    localparam logic [7:0] SAMP_FRAME_LO  = 8'd4;
    localparam logic [7:0] SAMP_FRAME_HI  = 8'd5;
    localparam logic [7:0] SAMP_GRANT_LO  = 8'd6;
    localparam logic [7:0] SAMP_GRANT_HI  = 8'd7;
    localparam logic [7:0] SAMP_PAD_LO    = 8'd9;
    localparam logic [7:0] SAMP_PAD_HI    = 8'd10;
    localparam logic [7:0] SAMP_EVENT     = 8'd11;
    localparam logic [7:0] SAMP_TRIGGER   = 8'd12;
    localparam logic [7:0] SAMP_HDR_LEN   = 8'd13;

    // One report; first declared member sits in the highest bits
    typedef struct packed {
        logic [23:0]        buffer_levels;
        logic signed [2:0]  group_id;
        logic [1:0]         bsr_kind;
        logic [2:0]         bsr_trigger;
        logic [1:0]         event_code;
        logic [15:0]        padding_bytes;
        logic [15:0]        grant_size;
        logic [11:0]        sysframe;
        logic [3:0]         subframe;
        logic [11:0]        first_sysframe;
        logic [3:0]         first_subframe;
    } result_t;

    localparam int RESULT_W = $bits(result_t);
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

@@ hw/rtl/mac_log_record_bsr_parser_core.sv @@
// Uplink MAC log record BSR parser. Raw record octets enter on the slave stream, one
// octet per item, with tuser[0] set on the first octet of each record. One report leaves
// on the master stream for every sample header, after the sample's last MAC subheader
// octet (or after the sample header when its header length is zero). The block takes one
// octet per clock cycle with no gaps while the receiver keeps up. An accepted octet sits
// in the input register while the combinational parser update runs; the report it
// completes is loaded into the report register when the octet moves on, and tvalid is
// driven from that register. While a report waits for the receiver, the octet in the
// input register is held and the input stalls, whether or not that octet would complete
// another report.
`include "mac_log_record_bsr_parser_core_defines.svh"

module mac_log_record_bsr_parser_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // data_octet
    input  logic [0:0]                          s_axis_tuser,  // record_start
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // first_subframe, first_sysframe, subframe, sysframe, grant_size, padding_bytes,
    // event_code, bsr_trigger, bsr_kind, group_id, buffer_levels, zero fill
    output logic [mlbp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    logic               in_valid_reg;
    logic [7:0]         in_octet_reg;
    logic               in_start_reg;
    logic               out_valid_reg;
    mlbp_pkg::result_t  out_data_reg;
    logic               advance;
    logic               par_valid;
    mlbp_pkg::result_t  par_res;

    // Octet moves on when the report slot is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_octet_reg <= s_axis_tdata;
            in_start_reg <= s_axis_tuser[0];
        end
    end

    mlbp_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .octet     (in_octet_reg),
        .start     (in_start_reg),
        .res_valid (par_valid),
        .res       (par_res)
    );

    // Report register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && par_valid)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && par_valid)
            out_data_reg <= par_res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(mlbp_pkg::OUT_TDATA_W - mlbp_pkg::RESULT_W){1'b0}},
                            out_data_reg};

    // Checks
    `MLBP_ASSERT_IMPLY(a_res_on_step, par_valid, advance,
        "parser produced a report without taking an octet")
    `MLBP_ASSERT_NEXT(a_res_loaded, advance && par_valid, m_axis_tvalid,
        "report was not presented after the completing octet")
    `MLBP_ASSERT_IMPLY(a_group_kind, m_axis_tvalid &&
        out_data_reg.bsr_kind != mlbp_pkg::KIND_SHORT,
        out_data_reg.group_id == mlbp_pkg::GROUP_NONE,
        "group set on a report that is not a short BSR")

endmodule

@@ hw/rtl/mlbp_parser.sv @@
// Parser state and per-octet update; one octet per step.
module mlbp_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          octet,
    input  logic                start,
    output logic                res_valid,
    output mlbp_pkg::result_t   res
);

    mlbp_pkg::phase_t   phase_reg, phase_next;
    mlbp_pkg::walk_t    walk_reg, walk_next;
    logic [7:0]         pos_reg, pos_next;
    logic [7:0]         subs_reg, subs_next;
    logic [7:0]         samps_reg, samps_next;
    logic [7:0]         low_reg, low_next;
    logic [15:0]        frame_reg, frame_next;
    logic [15:0]        grant_reg, grant_next;
    logic [15:0]        pad_reg, pad_next;
    logic [4:0]         evtrig_reg, evtrig_next;
    logic [7:0]         hdr_len_reg, hdr_len_next;
    logic [15:0]        first_frame_reg, first_frame_next;
    logic [1:0]         kind_reg, kind_next;
    logic signed [2:0]  group_reg, group_next;
    logic [23:0]        levels_reg, levels_next;
    logic               first_pend_reg, first_pend_next;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= mlbp_pkg::PH_IDLE;
            walk_reg        <= mlbp_pkg::WK_SUBHDR;
            pos_reg         <= '0;
            subs_reg        <= '0;
            samps_reg       <= '0;
            low_reg         <= '0;
            frame_reg       <= '0;
            grant_reg       <= '0;
            pad_reg         <= '0;
            evtrig_reg      <= '0;
            hdr_len_reg     <= '0;
            first_frame_reg <= '0;
            kind_reg        <= mlbp_pkg::KIND_NONE;
            group_reg       <= mlbp_pkg::GROUP_NONE;
            levels_reg      <= '0;
            first_pend_reg  <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            walk_reg        <= walk_next;
            pos_reg         <= pos_next;
            subs_reg        <= subs_next;
            samps_reg       <= samps_next;
            low_reg         <= low_next;
            frame_reg       <= frame_next;
            grant_reg       <= grant_next;
            pad_reg         <= pad_next;
            evtrig_reg      <= evtrig_next;
            hdr_len_reg     <= hdr_len_next;
            first_frame_reg <= first_frame_next;
            kind_reg        <= kind_next;
            group_reg       <= group_next;
            levels_reg      <= levels_next;
            first_pend_reg  <= first_pend_next;
        end
    end

    // Next state and report
    always_comb
    begin
        logic       finish;
        logic [4:0] lcid;
        logic       ext;

        finish           = 1'b0;
        lcid             = octet[4:0];
        ext              = octet[5];
        phase_next       = phase_reg;
        walk_next        = walk_reg;
        pos_next         = pos_reg;
        subs_next        = subs_reg;
        samps_next       = samps_reg;
        low_next         = low_reg;
        frame_next       = frame_reg;
        grant_next       = grant_reg;
        pad_next         = pad_reg;
        evtrig_next      = evtrig_reg;
        hdr_len_next     = hdr_len_reg;
        first_frame_next = first_frame_reg;
        kind_next        = kind_reg;
        group_next       = group_reg;
        levels_next      = levels_reg;
        first_pend_next  = first_pend_reg;

        if (step)
        begin
            // Record start drops whatever was in progress
            if (start)
            begin
                phase_next       = mlbp_pkg::PH_REC;
                walk_next        = mlbp_pkg::WK_SUBHDR;
                pos_next         = '0;
                subs_next        = '0;
                samps_next       = '0;
                low_next         = '0;
                frame_next       = '0;
                grant_next       = '0;
                pad_next         = '0;
                evtrig_next      = '0;
                hdr_len_next     = '0;
                first_frame_next = '0;
                kind_next        = mlbp_pkg::KIND_NONE;
                group_next       = mlbp_pkg::GROUP_NONE;
                levels_next      = '0;
                first_pend_next  = 1'b0;
            end

            case (phase_next)
                mlbp_pkg::PH_REC:
                begin
                    if (pos_next == '0)
                        subs_next = octet;
                    if (pos_next == mlbp_pkg::REC_HDR_LAST)
                    begin
                        pos_next   = '0;
                        phase_next = (subs_next != '0) ? mlbp_pkg::PH_SUB
                                                       : mlbp_pkg::PH_IDLE;
                    end
                    else
                        pos_next = pos_next + 8'd1;
                end

                mlbp_pkg::PH_SUB:
                begin
                    if (pos_next == mlbp_pkg::SUB_HDR_LAST)
                    begin
                        samps_next = octet;
                        pos_next   = '0;
                        if (subs_next != '0)
                            subs_next = subs_next - 8'd1;
                        first_pend_next = 1'b1;
                        if (samps_next != '0)
                            phase_next = mlbp_pkg::PH_SAMP;
                        else if (subs_next != '0)
                            phase_next = mlbp_pkg::PH_SUB;
                        else
                            phase_next = mlbp_pkg::PH_IDLE;
                    end
                    else
                        pos_next = pos_next + 8'd1;
                end

                mlbp_pkg::PH_SAMP:
                begin
                    // Sample header field capture, 16-bit words little-endian
                    case (pos_next) inside
                        mlbp_pkg::SAMP_FRAME_LO, mlbp_pkg::SAMP_GRANT_LO,
                        mlbp_pkg::SAMP_PAD_LO:
                            low_next = octet;
                        mlbp_pkg::SAMP_FRAME_HI:
                        begin
                            frame_next = {octet, low_next};
                            if (first_pend_next)
                            begin
                                first_frame_next = frame_next;
                                first_pend_next  = 1'b0;
                            end
                        end
                        mlbp_pkg::SAMP_GRANT_HI:
                            grant_next = {octet, low_next};
                        mlbp_pkg::SAMP_PAD_HI:
                            pad_next = {octet, low_next};
                        mlbp_pkg::SAMP_EVENT:
                            evtrig_next = {3'b000, octet[1:0]};
                        mlbp_pkg::SAMP_TRIGGER:
                            evtrig_next = {octet[2:0], evtrig_next[1:0]};
                        default:
                        begin
                        end
                    endcase

                    if (pos_next == mlbp_pkg::SAMP_HDR_LEN)
                    begin
                        hdr_len_next = octet;
                        walk_next    = mlbp_pkg::WK_SUBHDR;
                        kind_next    = mlbp_pkg::KIND_NONE;
                        group_next   = mlbp_pkg::GROUP_NONE;
                        levels_next  = '0;
                        pos_next     = '0;
                        if (octet == '0)
                            finish = 1'b1;
                        else
                            phase_next = mlbp_pkg::PH_ELEM;
                    end
                    else
                        pos_next = pos_next + 8'd1;
                end

                mlbp_pkg::PH_ELEM:
                begin
                    // MAC subheader walk
                    case (walk_next)
                        mlbp_pkg::WK_SUBHDR:
                        begin
                            if (lcid == mlbp_pkg::LCID_SHORT_BSR)
                                kind_next = mlbp_pkg::KIND_SHORT;
                            else if (lcid == mlbp_pkg::LCID_LONG_BSR)
                                kind_next = mlbp_pkg::KIND_LONG;
                            else if (lcid == mlbp_pkg::LCID_PADDING &&
                                     kind_next == mlbp_pkg::KIND_NONE)
                                kind_next = mlbp_pkg::KIND_PAD;
                            if (ext && lcid <= mlbp_pkg::LCID_MAX_SDU)
                                walk_next = mlbp_pkg::WK_LEN1;
                            else if (!ext)
                                walk_next = mlbp_pkg::WK_CE0;
                        end
                        mlbp_pkg::WK_LEN1:
                            walk_next = octet[7] ? mlbp_pkg::WK_LEN2
                                                 : mlbp_pkg::WK_SUBHDR;
                        mlbp_pkg::WK_LEN2:
                            walk_next = mlbp_pkg::WK_SUBHDR;
                        mlbp_pkg::WK_CE0:
                        begin
                            if (kind_next == mlbp_pkg::KIND_SHORT)
                            begin
                                group_next = $signed({1'b0, octet[7:6]});
                                case (octet[7:6])
                                    2'd0:    levels_next = {octet[5:0], 18'd0};
                                    2'd1:    levels_next = {6'd0, octet[5:0], 12'd0};
                                    2'd2:    levels_next = {12'd0, octet[5:0], 6'd0};
                                    default: levels_next = {18'd0, octet[5:0]};
                                endcase
                                walk_next = mlbp_pkg::WK_DONE;
                            end
                            else if (kind_next == mlbp_pkg::KIND_LONG)
                            begin
                                levels_next = {octet, 16'd0};
                                walk_next   = mlbp_pkg::WK_CE1;
                            end
                            else
                                walk_next = mlbp_pkg::WK_DONE;
                        end
                        mlbp_pkg::WK_CE1:
                        begin
                            levels_next = levels_next | {8'd0, octet, 8'd0};
                            walk_next   = mlbp_pkg::WK_CE2;
                        end
                        mlbp_pkg::WK_CE2:
                        begin
                            levels_next = levels_next | {16'd0, octet};
                            walk_next   = mlbp_pkg::WK_DONE;
                        end
                        default:
                        begin
                        end
                    endcase
                    pos_next = pos_next + 8'd1;
                    if (pos_next >= hdr_len_next)
                        finish = 1'b1;
                end

                default:
                begin
                end
            endcase

            // End of sample: truncated CE clears the BSR, then step counters
            if (finish)
            begin
                if (walk_next == mlbp_pkg::WK_CE0 || walk_next == mlbp_pkg::WK_CE1 ||
                    walk_next == mlbp_pkg::WK_CE2)
                begin
                    kind_next   = mlbp_pkg::KIND_NONE;
                    group_next  = mlbp_pkg::GROUP_NONE;
                    levels_next = '0;
                end
                pos_next = '0;
                if (samps_next != '0)
                    samps_next = samps_next - 8'd1;
                if (samps_next != '0)
                    phase_next = mlbp_pkg::PH_SAMP;
                else if (subs_next != '0)
                    phase_next = mlbp_pkg::PH_SUB;
                else
                    phase_next = mlbp_pkg::PH_IDLE;
            end
        end

        res_valid          = finish;
        res.first_subframe = first_frame_next[3:0];
        res.first_sysframe = first_frame_next[15:4];
        res.subframe       = frame_next[3:0];
        res.sysframe       = frame_next[15:4];
        res.grant_size     = grant_next;
        res.padding_bytes  = pad_next;
        res.event_code     = evtrig_next[1:0];
        res.bsr_trigger    = evtrig_next[4:2];
        res.bsr_kind       = kind_next;
        res.group_id       = group_next;
        res.buffer_levels  = levels_next;
    end

endmodule

@@ bench/mac_log_record_bsr_parser_core_tb.sv @@
`timescale 1ns / 100ps

module mac_log_record_bsr_parser_core_tb;

    typedef logic [7:0] octet_q_t[$];

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_PRINTED = 60;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // data_octet
    logic [0:0] s_axis_tuser = 1'b0;    // record_start
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // first_subframe, first_sysframe, subframe, sysframe, grant_size, padding_bytes,
    // event_code, bsr_trigger, bsr_kind, group_id, buffer_levels, zero fill
    logic [mlbp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // Stimulus pacing
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    bit hold_off = 1'b0;
    int octets_sent = 0;
    int cut_budget = -1;

    int mismatch_count = 0;
    int quiet_cycles = 0;

    // Parser image
    mlbp_pkg::phase_t parse_ph;
    mlbp_pkg::walk_t walk_st;
    logic [7:0] pos;
    logic [7:0] subs_left;
    logic [7:0] samps_left;
    logic [7:0] lo_hold;
    logic [15:0] frame_w;
    logic [15:0] grant_w;
    logic [15:0] pad_w;
    logic [15:0] first_frame_w;
    logic [4:0] evtrig;
    logic [7:0] hdr_len;
    logic [1:0] kind;
    logic signed [2:0] grp;
    logic [23:0] levels;
    bit first_pend;

    mlbp_pkg::result_t expected_reports[$];

    mac_log_record_bsr_parser_core DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    //--------------------------------------------------------------------
    // Parser image: clear, subheader walk, sample close, octet step
    //--------------------------------------------------------------------
    task clear_parser();
        parse_ph = mlbp_pkg::PH_IDLE;
        walk_st = mlbp_pkg::WK_SUBHDR;
        pos = '0;
        subs_left = '0;
        samps_left = '0;
        lo_hold = '0;
        frame_w = '0;
        grant_w = '0;
        pad_w = '0;
        first_frame_w = '0;
        evtrig = '0;
        hdr_len = '0;
        kind = mlbp_pkg::KIND_NONE;
        grp = mlbp_pkg::GROUP_NONE;
        levels = '0;
        first_pend = 1'b0;
    endtask

    task walk_subheader(input logic [7:0] v);
        logic [4:0] lcid;
        int sh;
        lcid = v[4:0];
        case (walk_st)
            mlbp_pkg::WK_SUBHDR:
            begin
                if (lcid == mlbp_pkg::LCID_SHORT_BSR)
                    kind = mlbp_pkg::KIND_SHORT;
                else if (lcid == mlbp_pkg::LCID_LONG_BSR)
                    kind = mlbp_pkg::KIND_LONG;
                else if (lcid == mlbp_pkg::LCID_PADDING && kind == mlbp_pkg::KIND_NONE)
                    kind = mlbp_pkg::KIND_PAD;
                if (v[5] && lcid <= mlbp_pkg::LCID_MAX_SDU)
                    walk_st = mlbp_pkg::WK_LEN1;
                else if (!v[5])
                    walk_st = mlbp_pkg::WK_CE0;
            end
            mlbp_pkg::WK_LEN1:
                walk_st = v[7] ? mlbp_pkg::WK_LEN2 : mlbp_pkg::WK_SUBHDR;
            mlbp_pkg::WK_LEN2:
                walk_st = mlbp_pkg::WK_SUBHDR;
            mlbp_pkg::WK_CE0:
            begin
                if (kind == mlbp_pkg::KIND_SHORT)
                begin
                    // group in bits 7..6, index placed in that group's slot
                    grp = {1'b0, v[7:6]};
                    sh = 18 - 6 * int'(v[7:6]);
                    levels = {18'b0, v[5:0]} << sh;
                    walk_st = mlbp_pkg::WK_DONE;
                end
                else if (kind == mlbp_pkg::KIND_LONG)
                begin
                    levels = {v, 16'h0000};
                    walk_st = mlbp_pkg::WK_CE1;
                end
                else
                    walk_st = mlbp_pkg::WK_DONE;
            end
            mlbp_pkg::WK_CE1:
            begin
                levels[15:8] = v;
                walk_st = mlbp_pkg::WK_CE2;
            end
            mlbp_pkg::WK_CE2:
            begin
                levels[7:0] = v;
                walk_st = mlbp_pkg::WK_DONE;
            end
            default:
                ;
        endcase
    endtask

    task close_sample();
        mlbp_pkg::result_t r;
        // control element cut short by the header length
        if (walk_st == mlbp_pkg::WK_CE0 || walk_st == mlbp_pkg::WK_CE1 ||
            walk_st == mlbp_pkg::WK_CE2)
        begin
            kind = mlbp_pkg::KIND_NONE;
            grp = mlbp_pkg::GROUP_NONE;
            levels = '0;
        end
        r.first_subframe = first_frame_w[3:0];
        r.first_sysframe = first_frame_w[15:4];
        r.subframe = frame_w[3:0];
        r.sysframe = frame_w[15:4];
        r.grant_size = grant_w;
        r.padding_bytes = pad_w;
        r.event_code = evtrig[1:0];
        r.bsr_trigger = evtrig[4:2];
        r.bsr_kind = kind;
        r.group_id = grp;
        r.buffer_levels = levels;
        expected_reports.push_back(r);

        pos = '0;
        if (samps_left != 0)
            samps_left--;
        if (samps_left != 0)
            parse_ph = mlbp_pkg::PH_SAMP;
        else if (subs_left != 0)
            parse_ph = mlbp_pkg::PH_SUB;
        else
            parse_ph = mlbp_pkg::PH_IDLE;
    endtask

    task parse_octet(input logic [7:0] v, input logic start);
        if (start)
        begin
            clear_parser();
            parse_ph = mlbp_pkg::PH_REC;
        end
        case (parse_ph)
            mlbp_pkg::PH_REC:
            begin
                if (pos == 0)
                    subs_left = v;
                if (pos == mlbp_pkg::REC_HDR_LAST)
                begin
                    pos = '0;
                    parse_ph = (subs_left != 0) ? mlbp_pkg::PH_SUB : mlbp_pkg::PH_IDLE;
                end
                else
                    pos++;
            end
            mlbp_pkg::PH_SUB:
            begin
                if (pos == mlbp_pkg::SUB_HDR_LAST)
                begin
                    samps_left = v;
                    pos = '0;
                    if (subs_left != 0)
                        subs_left--;
                    first_pend = 1'b1;
                    if (samps_left != 0)
                        parse_ph = mlbp_pkg::PH_SAMP;
                    else if (subs_left != 0)
                        parse_ph = mlbp_pkg::PH_SUB;
                    else
                        parse_ph = mlbp_pkg::PH_IDLE;
                end
                else
                    pos++;
            end
            mlbp_pkg::PH_SAMP:
            begin
                case (pos)
                    mlbp_pkg::SAMP_FRAME_LO, mlbp_pkg::SAMP_GRANT_LO,
                    mlbp_pkg::SAMP_PAD_LO:
                        lo_hold = v;
                    mlbp_pkg::SAMP_FRAME_HI:
                    begin
                        frame_w = {v, lo_hold};
                        if (first_pend)
                        begin
                            first_frame_w = frame_w;
                            first_pend = 1'b0;
                        end
                    end
                    mlbp_pkg::SAMP_GRANT_HI:
                        grant_w = {v, lo_hold};
                    mlbp_pkg::SAMP_PAD_HI:
                        pad_w = {v, lo_hold};
                    mlbp_pkg::SAMP_EVENT:
                        evtrig = {3'b000, v[1:0]};
                    mlbp_pkg::SAMP_TRIGGER:
                        evtrig = {v[2:0], evtrig[1:0]};
                    default:
                        ;
                endcase
                if (pos == mlbp_pkg::SAMP_HDR_LEN)
                begin
                    hdr_len = v;
                    walk_st = mlbp_pkg::WK_SUBHDR;
                    kind = mlbp_pkg::KIND_NONE;
                    grp = mlbp_pkg::GROUP_NONE;
                    levels = '0;
                    pos = '0;
                    if (hdr_len == 0)
                        close_sample();
                    else
                        parse_ph = mlbp_pkg::PH_ELEM;
                end
                else
                    pos++;
            end
            mlbp_pkg::PH_ELEM:
            begin
                walk_subheader(v);
                pos++;
                if (pos >= hdr_len)
                    close_sample();
            end
            default:
                ;
        endcase
    endtask

    //--------------------------------------------------------------------
    // Octet sender, called at a falling edge and returning at one
    //--------------------------------------------------------------------
    task send_octet(input logic [7:0] v, input logic start);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = v;
        s_axis_tuser = start;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        parse_octet(v, start);
        octets_sent++;
        @(negedge clk);
    endtask

    // Record octet; dropped once a cut record has used up its budget
    task rec_octet(input logic [7:0] v, input logic start);
        if (cut_budget == 0)
            return;
        if (cut_budget > 0)
            cut_budget--;
        send_octet(v, start);
    endtask

    task send_record_header(input logic [7:0] n_sub);
        rec_octet(n_sub, 1'b1);
        repeat (3)
            rec_octet(8'($urandom), 1'b0);
    endtask

    task send_subpacket_header(input logic [7:0] n_samp);
        repeat (4)
            rec_octet(8'($urandom), 1'b0);
        rec_octet(n_samp, 1'b0);
    endtask

    task send_sample(input logic [15:0] frame, input logic [15:0] grant,
                     input logic [15:0] pad, input logic [7:0] ev_octet,
                     input logic [7:0] trig_octet, input octet_q_t mac);
        repeat (4)
            rec_octet(8'($urandom), 1'b0);
        rec_octet(frame[7:0], 1'b0);
        rec_octet(frame[15:8], 1'b0);
        rec_octet(grant[7:0], 1'b0);
        rec_octet(grant[15:8], 1'b0);
        rec_octet(8'($urandom), 1'b0);
        rec_octet(pad[7:0], 1'b0);
        rec_octet(pad[15:8], 1'b0);
        rec_octet(ev_octet, 1'b0);
        rec_octet(trig_octet, 1'b0);
        rec_octet(8'(mac.size()), 1'b0);
        foreach (mac[i])
            rec_octet(mac[i], 1'b0);
    endtask

    //--------------------------------------------------------------------
    // Random content
    //--------------------------------------------------------------------
    function automatic logic [15:0] pick_word();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly well-formed subheader chains; some noise, some cut short
    task build_subheaders(output octet_q_t q);
        int n_sdu;
        int pick;
        logic [7:0] len_octet;
        q = {};
        pick = $urandom_range(49);
        if (pick == 0)
        begin
            repeat (255)
                q.push_back(8'($urandom));
            return;
        end
        if (pick < 5)
            return;
        if (pick < 10)
        begin
            repeat ($urandom_range(1, 12))
                q.push_back(8'($urandom));
            return;
        end
        // SDU subheaders with 7- or 15-bit length
        n_sdu = $urandom_range(3);
        repeat (n_sdu)
        begin
            q.push_back({2'($urandom_range(3)), 1'b1, 5'($urandom_range(11))});
            len_octet = 8'($urandom);
            q.push_back(len_octet);
            if (len_octet[7])
                q.push_back(8'($urandom));
        end
        // control subheaders still flagged as not last
        repeat ($urandom_range(2) == 0 ? 1 : 0)
            q.push_back({2'($urandom_range(3)), 1'b1, 5'($urandom_range(12, 31))});
        // last subheader and its control element
        case ($urandom_range(4))
            0, 1:
            begin
                q.push_back({2'($urandom_range(3)), 1'b0, mlbp_pkg::LCID_SHORT_BSR});
                q.push_back(8'($urandom));
            end
            2:
            begin
                q.push_back({2'($urandom_range(3)), 1'b0, mlbp_pkg::LCID_LONG_BSR});
                repeat (3)
                    q.push_back(8'($urandom));
            end
            3:
            begin
                q.push_back({2'($urandom_range(3)), 1'b0, mlbp_pkg::LCID_PADDING});
                repeat ($urandom_range(1))
                    q.push_back(8'($urandom));
            end
            default:
            begin
                q.push_back({2'($urandom_range(3)), 1'b0, 5'($urandom_range(28))});
                q.push_back(8'($urandom));
            end
        endcase
        // octets past the control element
        repeat ($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0)
            q.push_back(8'($urandom));
        // header length shorter than the chain
        if ($urandom_range(4) == 0 && q.size() > 1)
            q = q[0:$urandom_range(q.size() - 2)];
    endtask

    task send_random_record();
        int n_sub;
        int n_samp;
        octet_q_t mac;
        n_sub = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(3);
        cut_budget = ($urandom_range(9) == 0) ? $urandom_range(1, 60) : -1;
        send_record_header(8'(n_sub));
        for (int s = 0; s < n_sub && s < 3; s++)
        begin
            n_samp = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(3);
            send_subpacket_header(8'(n_samp));
            for (int k = 0; k < n_samp && k < 3; k++)
            begin
                build_subheaders(mac);
                send_sample(pick_word(), pick_word(), pick_word(), 8'($urandom),
                            8'($urandom), mac);
            end
        end
        cut_budget = -1;
        // stray octets between records
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3))
                send_octet(8'($urandom), 1'b0);
    endtask

    //--------------------------------------------------------------------
    // Tests
    //--------------------------------------------------------------------
    task test_idle_octets();
        send_octet(8'hFF, 1'b0);
        send_octet(8'h00, 1'b0);
        send_octet(8'h5A, 1'b0);
    endtask

    task test_empty_counts();
        octet_q_t mac;
        mac = {};
        send_record_header(8'd0);
        send_record_header(8'd2);
        send_subpacket_header(8'd0);
        send_subpacket_header(8'd2);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, mac);
        mac = {8'h1D, 8'h3F};
        send_sample(16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, mac);
    endtask

    task test_bsr_kinds();
        octet_q_t mac;
        send_record_header(8'd1);
        send_subpacket_header(8'd7);
        // short BSR after SDU subheaders with both length forms
        mac = {8'h21, 8'h40, 8'h23, 8'h80, 8'h05, 8'h1D, 8'h3F};
        send_sample(16'h1234, 16'h0100, 16'h0002, 8'h01, 8'h03, mac);
        mac = {8'h1D, 8'h6A};
        send_sample(16'h4321, 16'h00FF, 16'h0000, 8'h02, 8'h06, mac);
        mac = {8'h1D, 8'hBF};
        send_sample(16'h8001, 16'h7FFF, 16'h8000, 8'h03, 8'h00, mac);
        mac = {8'h1E, 8'hFF, 8'h00, 8'hA5};
        send_sample(16'hFFF0, 16'h0001, 16'h00FF, 8'hFC, 8'hF8, mac);
        // short flagged not-last, then padding as last: short wins
        mac = {8'h3D, 8'h1F, 8'hC7};
        send_sample(16'h000F, 16'hABCD, 16'h1357, 8'h01, 8'h05, mac);
        mac = {8'h1F, 8'h00};
        send_sample(16'h5555, 16'hAAAA, 16'h5555, 8'h02, 8'h07, mac);
        // plain SDU as last subheader
        mac = {8'h01, 8'h00};
        send_sample(16'hAAAA, 16'h5555, 16'hAAAA, 8'h00, 8'h01, mac);
    endtask

    task test_truncation();
        octet_q_t mac;
        send_record_header(8'd1);
        send_subpacket_header(8'd5);
        mac = {8'h1D};
        send_sample(16'h0010, 16'h0020, 16'h0030, 8'h01, 8'h02, mac);
        mac = {8'h1E, 8'hAA, 8'h55};
        send_sample(16'h0011, 16'h0021, 16'h0031, 8'h02, 8'h03, mac);
        mac = {8'h1F};
        send_sample(16'h0012, 16'h0022, 16'h0032, 8'h03, 8'h04, mac);
        // second length octet lies past the header length
        mac = {8'h23, 8'h80};
        send_sample(16'h0013, 16'h0023, 16'h0033, 8'h00, 8'h05, mac);
        // octets after the control element are skipped
        mac = {8'h1D, 8'h4C, 8'hFF, 8'h1E};
        send_sample(16'h0014, 16'h0024, 16'h0034, 8'h01, 8'h06, mac);
    endtask

    task test_restart();
        octet_q_t mac;
        mac = {8'h1D, 8'h11};
        send_record_header(8'd1);
        send_subpacket_header(8'd2);
        send_sample(16'hBEEF, 16'h0042, 16'h0007, 8'h01, 8'h02, mac);
        // second sample abandoned halfway
        cut_budget = 8;
        send_sample(16'hCAFE, 16'h0043, 16'h0008, 8'h02, 8'h03, mac);
        cut_budget = -1;
        // restart inside a record header
        send_octet(8'h03, 1'b1);
        send_octet(8'h77, 1'b0);
        send_record_header(8'd1);
        send_subpacket_header(8'd1);
        send_sample(16'h0F0F, 16'h1111, 16'h2222, 8'h03, 8'h04, mac);
    endtask

    task test_random_records(input int n_octets, input int idle_pct, input int stall_pct);
        int target;
        src_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        target = octets_sent + n_octets;
        while (octets_sent < target)
            send_random_record();
    endtask

    // Receiver holds off while a record of header-only samples streams in
    task test_backpressure();
        octet_q_t mac;
        mac = {};
        src_idle_pct = 0;
        sink_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (HOLD_OFF_CYCLES)
                    @(posedge clk);
                hold_off = 1'b0;
            end
        join_none
        send_record_header(8'd1);
        send_subpacket_header(8'd40);
        repeat (40)
            send_sample(pick_word(), pick_word(), pick_word(), 8'($urandom),
                        8'($urandom), mac);
    endtask

    //--------------------------------------------------------------------
    // Receiver ready
    //--------------------------------------------------------------------
    always @(negedge clk)
        m_axis_tready <= hold_off ? 1'b0 : ($urandom_range(99) >= sink_stall_pct);

    //--------------------------------------------------------------------
    // Report checking
    //--------------------------------------------------------------------
    task report_mismatch(input string field, input logic [31:0] got,
                         input logic [31:0] want);
        if (got !== want)
        begin
            if (mismatch_count < MAX_PRINTED)
                $display("%0t: mismatch %s got %h want %h", $realtime, field, got, want);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : report_check
        mlbp_pkg::result_t got;
        mlbp_pkg::result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = mlbp_pkg::result_t'(m_axis_tdata[mlbp_pkg::RESULT_W-1:0]);
            if (expected_reports.size() == 0)
            begin
                if (mismatch_count < MAX_PRINTED)
                    $display("%0t: report with none pending", $realtime);
                mismatch_count++;
            end
            else
            begin
                want = expected_reports.pop_front();
                report_mismatch("first_subframe", got.first_subframe, want.first_subframe);
                report_mismatch("first_sysframe", got.first_sysframe, want.first_sysframe);
                report_mismatch("subframe", got.subframe, want.subframe);
                report_mismatch("sysframe", got.sysframe, want.sysframe);
                report_mismatch("grant_size", got.grant_size, want.grant_size);
                report_mismatch("padding_bytes", got.padding_bytes, want.padding_bytes);
                report_mismatch("event_code", got.event_code, want.event_code);
                report_mismatch("bsr_trigger", got.bsr_trigger, want.bsr_trigger);
                report_mismatch("bsr_kind", got.bsr_kind, want.bsr_kind);
                report_mismatch("group_id", got.group_id, want.group_id);
                report_mismatch("buffer_levels", got.buffer_levels, want.buffer_levels);
                report_mismatch("zero_fill",
                    m_axis_tdata[mlbp_pkg::OUT_TDATA_W-1:mlbp_pkg::RESULT_W], '0);
            end
        end
    end

    //--------------------------------------------------------------------
    // Watchdog: cycles with no item moving on either side
    //--------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    //--------------------------------------------------------------------
    // Sequence
    //--------------------------------------------------------------------
    initial
    begin
        clear_parser();
        repeat (6)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_idle_octets();
        test_empty_counts();
        test_bsr_kinds();
        test_truncation();
        test_restart();
        test_random_records(250, 0, 0);
        test_random_records(250, 53, 0);
        test_random_records(250, 0, 53);
        test_random_records(250, 15, 15);
        test_backpressure();
        s_axis_tvalid = 1'b0;

        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/mlbp_pkg.sv
hw/rtl/mlbp_parser.sv
hw/rtl/mac_log_record_bsr_parser_core.sv
bench/mac_log_record_bsr_parser_core_tb.sv
